### design/rvig_pkg.sv
// shared types and constants for the radial vignette block
`default_nettype none
package rvig_pkg;
  localparam int unsigned MaxDim = 4096;
  localparam int unsigned CfgW = 13;
  localparam int unsigned CntW = 12;
  localparam int unsigned D2W = 27;
  localparam int unsigned SqW = 44;
  localparam int unsigned RootW = 22;
  localparam int unsigned FullW = 22;
  localparam int unsigned ProdW = 30;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_MUL, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic mul;
    logic div_step;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } sts_t;

  function automatic logic [CfgW-1:0] eff_dim(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] r;
    r = v;
    if (v == '0) r = CfgW'(1);
    else if (v > CfgW'(MaxDim)) r = CfgW'(MaxDim);
    return r;
  endfunction
endpackage
`default_nettype wire

### design/rvig_if.sv
// valid/ready channel interfaces
`default_nettype none
interface rvig_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;
  modport source(output valid, red, green, blue, frame_end, input ready);
  modport sink(input valid, red, green, blue, frame_end, output ready);
endinterface

interface rvig_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/rvig_ctrl.sv
// controller state machine for the vignette datapath
`default_nettype none
module rvig_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire rvig_pkg::sts_t sts,
  output rvig_pkg::cmd_t      cmd,
  output logic                in_rdy,
  output logic                out_vld
);
  rvig_pkg::state_t state_r, state_nxt;
  logic obuf_vld_r, obuf_vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rvig_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) obuf_vld_r <= 1'b0;
    else obuf_vld_r <= obuf_vld_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_rdy = 1'b0;
    out_vld = obuf_vld_r;
    obuf_vld_nxt = obuf_vld_r && !out_free;
    unique case (state_r)
      rvig_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = rvig_pkg::ST_SQRT;
        end
      end
      rvig_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_nxt = rvig_pkg::ST_MUL;
      end
      rvig_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = rvig_pkg::ST_DIV;
      end
      rvig_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = rvig_pkg::ST_OUT;
      end
      rvig_pkg::ST_OUT: begin
        if (!obuf_vld_r || out_free) begin
          cmd.advance = 1'b1;
          obuf_vld_nxt = 1'b1;
          state_nxt = rvig_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rvig_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### design/rvig_dp.sv
// datapath: position counters, bitwise square root, restoring divider
`default_nettype none
module rvig_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rvig_pkg::cmd_t             cmd,
  input  wire logic [rvig_pkg::CfgW-1:0]  width_cfg,
  input  wire logic [rvig_pkg::CfgW-1:0]  height_cfg,
  input  wire logic [7:0]                 red_i,
  input  wire logic [7:0]                 green_i,
  input  wire logic [7:0]                 blue_i,
  output rvig_pkg::sts_t                  sts,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic                            frame_end_o
);
  localparam int unsigned CW = rvig_pkg::CntW;
  localparam int unsigned FW = rvig_pkg::FullW;
  localparam int unsigned PW = rvig_pkg::ProdW;
  localparam int unsigned SW = rvig_pkg::SqW;
  localparam int unsigned RW = rvig_pkg::RootW;
  localparam int unsigned DW = rvig_pkg::D2W;

  logic [CW-1:0] col_r, row_r;
  logic [7:0] pix_r [3];
  logic [RW-1:0] root_r;
  logic [4:0] sq_cnt_r;
  logic [FW-1:0] full_r;
  logic [FW-1:0] num_r;
  logic [PW-1:0] prod_r [3];
  logic [FW:0] drem_r [3];
  logic [7:0] quo_r [3];
  logic [3:0] div_cnt_r;
  logic last_r;
  logic mul_d_r;

  logic [rvig_pkg::CfgW-1:0] w_eff, h_eff;
  logic [13:0] dx, dy, twoc, twor;
  logic [DW-1:0] d2;
  logic last_col, last_row;

  always_comb begin
    w_eff = rvig_pkg::eff_dim(width_cfg);
    h_eff = rvig_pkg::eff_dim(height_cfg);
    twoc = {1'b0, col_r, 1'b0};
    twor = {1'b0, row_r, 1'b0};
    dx = (twoc >= 14'(w_eff)) ? twoc - 14'(w_eff) : 14'(w_eff) - twoc;
    dy = (twor >= 14'(h_eff)) ? twor - 14'(h_eff) : 14'(h_eff) - twor;
    d2 = DW'(dx) * DW'(dx) + DW'(dy) * DW'(dy);
    last_col = {1'b0, col_r} >= w_eff - 13'd1;
    last_row = {1'b0, row_r} >= h_eff - 13'd1;
  end

  // square root: radicand held in a shift register, remainder separate
  logic [SW-1:0] rad_r;
  logic [RW+1:0] sqrem_r;
  logic [RW+1:0] sq_next;
  logic [RW+1:0] sq_try;
  always_comb begin
    sq_next = {sqrem_r[RW-1:0], rad_r[SW-1 -: 2]};
    sq_try = sq_next - {root_r, 2'b01};
  end

  assign sts.sqrt_done = (sq_cnt_r == 5'd21);
  assign sts.div_done = (div_cnt_r == 4'd8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.advance) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + CW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r[0] <= red_i;
      pix_r[1] <= green_i;
      pix_r[2] <= blue_i;
      rad_r <= SW'({d2, 16'd0});
      sqrem_r <= '0;
      root_r <= '0;
      sq_cnt_r <= '0;
      full_r <= {h_eff[FW-10:0], 9'd0};
      last_r <= last_col && last_row;
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[SW-3:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + 5'd1;
      if (!sq_try[RW+1]) begin
        sqrem_r <= sq_try;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        sqrem_r <= sq_next;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      num_r <= (FW'(root_r) < full_r) ? full_r - FW'(root_r) : '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step && !mul_d_r) begin
      div_cnt_r <= div_cnt_r + 4'd1;
    end
  end

  // products computed once, then eight restoring quotient bits
  logic [FW:0] dtry [3];
  logic [FW:0] dsh [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsh[k] = {drem_r[k][FW-1:0], prod_r[k][PW-1]};
      dtry[k] = dsh[k] - {1'b0, full_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mul_d_r <= 1'b0;
    else mul_d_r <= cmd.mul;
  end

  always_ff @(posedge clk) begin
    if (mul_d_r) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PW'(pix_r[k]) * PW'(num_r);
        quo_r[k] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        if (div_cnt_r == 4'd0) begin
          // quotient < 256, so the top 22 product bits are below full
          drem_r[k] <= {1'b0, prod_r[k][PW-1 -: FW]};
          prod_r[k] <= {prod_r[k][PW-FW-1:0], {FW{1'b0}}};
          quo_r[k] <= '0;
        end else begin
          prod_r[k] <= {prod_r[k][PW-2:0], 1'b0};
          if (!dtry[k][FW]) begin
            drem_r[k] <= dtry[k];
            quo_r[k] <= {quo_r[k][6:0], 1'b1};
          end else begin
            drem_r[k] <= dsh[k];
            quo_r[k] <= {quo_r[k][6:0], 1'b0};
          end
        end
      end
    end else if (cmd.advance) begin
      for (int k = 0; k < 3; k++) begin
        quo_r[k] <= quo_r[k];
      end
    end
  end

  // final quotient bit resolved when leaving the divide state
  logic [7:0] res_r [3];
  always_ff @(posedge clk) begin
    if (sts.div_done && cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        res_r[k] <= !dtry[k][FW] ? {quo_r[k][6:0], 1'b1} : {quo_r[k][6:0], 1'b0};
      end
    end
  end

  // output register, frees the datapath while a word waits
  logic [7:0] obuf_r [3];
  logic obuf_fe_r;
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      for (int k = 0; k < 3; k++) begin
        obuf_r[k] <= res_r[k];
      end
      obuf_fe_r <= last_r;
    end
  end

  assign red_o = obuf_r[0];
  assign green_o = obuf_r[1];
  assign blue_o = obuf_r[2];
  assign frame_end_o = obuf_fe_r;
endmodule
`default_nettype wire

### design/radial_vignette_pixel.sv
// top level of the radial vignette block
// a new word is taken only when idle, and the next word computes while a result waits
// the square root takes 22 steps; the divider computes the product, aligns it
// and then resolves 8 quotient bits
// reset: synchronous active low, position counters cleared, width 640, height 480
`default_nettype none
module radial_vignette_pixel (
  input wire logic   clk,
  input wire logic   rst_n,
  rvig_pix_if.sink   in_ch,
  rvig_pix_if.source out_ch,
  rvig_cfg_if.sink   cfg_ch
);
  logic [rvig_pkg::CfgW-1:0] width_r, height_r;
  rvig_pkg::cmd_t cmd;
  rvig_pkg::sts_t sts;
  logic in_rdy, out_vld;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= rvig_pkg::CfgW'(640);
      height_r <= rvig_pkg::CfgW'(480);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == rvig_pkg::REG_WIDTH) width_r <= cfg_ch.data;
      else height_r <= cfg_ch.data;
    end
  end

  rvig_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_ch.valid && in_rdy),
    .out_free(out_ch.ready),
    .sts, .cmd, .in_rdy, .out_vld
  );

  rvig_dp u_dp (
    .clk, .rst_n, .cmd,
    .width_cfg(width_r), .height_cfg(height_r),
    .red_i(in_ch.red), .green_i(in_ch.green), .blue_i(in_ch.blue),
    .sts,
    .red_o(out_ch.red), .green_o(out_ch.green), .blue_o(out_ch.blue),
    .frame_end_o(out_ch.frame_end)
  );

  assign in_ch.ready = in_rdy;
  assign out_ch.valid = out_vld;
endmodule
`default_nettype wire

### design/rvig_chk.sv
// port checker for the radial vignette block
`default_nettype none
module rvig_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic       out_frame_end
);
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready) [*30]) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable({out_red, out_green, out_blue, out_frame_end}))
    else $error("result changed while waiting");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_ready, out_valid})) else $error("handshake unknown");
endmodule

bind radial_vignette_pixel rvig_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_red(out_ch.red), .out_green(out_ch.green), .out_blue(out_ch.blue),
  .out_frame_end(out_ch.frame_end)
);
`default_nettype wire
